@@ sv/packed_date_unpacker_with_parity_assert.svh @@
// ----------------------------------------------------------------------------
// packed_date_unpacker_with_parity_assert.svh
// Assertion macros shared by the checker of the date unpacker.
// ----------------------------------------------------------------------------
`ifndef PACKED_DATE_UNPACKER_WITH_PARITY_ASSERT_SVH
`define PACKED_DATE_UNPACKER_WITH_PARITY_ASSERT_SVH

// Same-cycle implication, ignored while reset is high
`define PDU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high
`define PDU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also checks across reset
`define PDU_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/pdu_pkg.sv @@
// ----------------------------------------------------------------------------
// pdu_pkg
// Shared constants and types of the packed date unpacker.
// ----------------------------------------------------------------------------
package pdu_pkg;

   localparam int RECORD_BITS = 15;
   localparam int WORD_BITS   = 32;
   localparam int PART_BITS   = RECORD_BITS - 1;          // unfinished record bits
   localparam int HAVE_W      = 4;                        // holds 0..PART_BITS
   localparam int MAX_RECS    = 3;                        // records one word can finish
   localparam int SPAN_BITS   = MAX_RECS * RECORD_BITS;   // bits carried per request
   localparam int COUNT_W     = 16;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 11;
   localparam int YOFS_W  = 6;
   localparam logic [YEAR_W-1:0] YEAR_BASE = 11'd1970;

   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

   // One classified request: the aligned record bits and which records to emit
   typedef struct packed {
      logic [SPAN_BITS-1:0] bits;
      logic [MAX_RECS-1:0]  mask;
   } job_type;

endpackage

@@ sv/packed_date_unpacker_with_parity.sv @@
// Path: a record passes through the request queue and then the result register
//   on its way to the result ports.
// Throughput: one word per cycle while the 4-deep request queue has room; the back
//   half emits one record per cycle while results are taken; 0 to 3 per word.
// Reset (synchronous): queue and result register empty, partial record and frame
//   count cleared, record count back to 1.
// ----------------------------------------------------------------------------
// packed_date_unpacker_with_parity
// Unpacks 15-bit date records from parity-checked 32-bit words.
// ----------------------------------------------------------------------------
module packed_date_unpacker_with_parity (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pdu_pkg::WORD_BITS-1:0] req_packet_word,
   input  logic                          req_parity_bit,
   input  logic                          push,
   output logic                          full,
   output logic [pdu_pkg::DAY_W-1:0]     rsp_day,
   output logic [pdu_pkg::MONTH_W-1:0]   rsp_month,
   output logic [pdu_pkg::YEAR_W-1:0]    rsp_year,
   output logic                          rsp_last_of_word,
   output logic                          empty,
   input  logic                          pop,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pdu_pkg::COUNT_W-1:0]   csr_record_count
);
   import pdu_pkg::*;

   job_type wr_job, head_job;
   logic    accept, job_push, job_pop, job_valid;

   // Take a request when the queue has room
   assign accept    = push && !full;
   assign csr_ready = 1'b1;

   pdu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_packet_word  (req_packet_word),
      .req_parity_bit   (req_parity_bit),
      .accept           (accept),
      .csr_write        (csr_valid && csr_ready),
      .csr_record_count (csr_record_count),
      .job              (wr_job),
      .job_push         (job_push)
   );

   pdu_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (job_push),
      .wr_data   (wr_job),
      .rd_en     (job_pop),
      .rd_data   (head_job),
      .not_empty (job_valid),
      .is_full   (full)
   );

   pdu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job              (head_job),
      .job_valid        (job_valid),
      .job_pop          (job_pop),
      .rsp_day          (rsp_day),
      .rsp_month        (rsp_month),
      .rsp_year         (rsp_year),
      .rsp_last_of_word (rsp_last_of_word),
      .empty            (empty),
      .pop              (pop)
   );

endmodule

@@ sv/pdu_front.sv @@
// ----------------------------------------------------------------------------
// pdu_front
// Checks word parity, aligns the word behind the unfinished record, counts
// records against the frame length and picks the records to emit.
// ----------------------------------------------------------------------------
module pdu_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pdu_pkg::WORD_BITS-1:0] req_packet_word,
   input  logic                          req_parity_bit,
   input  logic                          accept,
   input  logic                          csr_write,
   input  logic [pdu_pkg::COUNT_W-1:0]   csr_record_count,
   output pdu_pkg::job_type              job,
   output logic                          job_push
);
   import pdu_pkg::*;

   localparam int VEC_W = SPAN_BITS + 1;

   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [PART_BITS-1:0] partial_ff, partial_in;
   logic [HAVE_W-1:0]    have_ff, have_in;
   logic                 taint_ff, taint_in;
   logic [COUNT_W-1:0]   done_ff, done_in;

   logic                 bad;
   logic [VEC_W-1:0]     vec;
   logic                 three;
   logic [COUNT_W:0]     limit, done1, done2, done3;
   logic                 end1, end2, end3, frame_end;
   logic [HAVE_W-1:0]    have_left;
   logic [MAX_RECS-1:0]  mask;

   // Classify the incoming word
   always_comb begin
      bad   = (^req_packet_word) != req_parity_bit;
      vec   = ({{PART_BITS{1'b0}}, req_packet_word} << have_ff)
              | {{(VEC_W - PART_BITS){1'b0}}, partial_ff};
      three = have_ff >= HAVE_W'(3 * RECORD_BITS - WORD_BITS);
      limit = (count_ff == '0) ? (COUNT_W + 1)'(1) : {1'b0, count_ff};
      done1 = {1'b0, done_ff} + (COUNT_W + 1)'(1);
      done2 = {1'b0, done_ff} + (COUNT_W + 1)'(2);
      done3 = {1'b0, done_ff} + (COUNT_W + 1)'(3);
      end1  = done1 >= limit;
      end2  = !end1 && (done2 >= limit);
      end3  = three && !end1 && !end2 && (done3 >= limit);
      frame_end = end1 || end2 || end3;

      mask[0] = !bad && !taint_ff;
      mask[1] = !bad && !end1;
      mask[2] = !bad && three && !end1 && !end2;

      job.bits = vec[SPAN_BITS-1:0];
      job.mask = mask;
      job_push = accept && (mask != '0);

      // Carry the leftover bits into the next word
      if (three) begin
         have_left = have_ff - HAVE_W'(3 * RECORD_BITS - WORD_BITS);
         partial_in = {{(PART_BITS - 1){1'b0}}, vec[SPAN_BITS]};
      end else begin
         have_left = have_ff + HAVE_W'(WORD_BITS - 2 * RECORD_BITS);
         partial_in = vec[2*RECORD_BITS +: PART_BITS];
      end

      count_in = csr_write ? csr_record_count : count_ff;
      have_in  = have_ff;
      taint_in = taint_ff;
      done_in  = done_ff;
      if (accept) begin
         if (frame_end) begin
            have_in    = '0;
            taint_in   = 1'b0;
            done_in    = '0;
            partial_in = '0;
         end else begin
            have_in  = have_left;
            taint_in = bad && (have_left != '0);
            done_in  = three ? done3[COUNT_W-1:0] : done2[COUNT_W-1:0];
         end
      end else begin
         partial_in = partial_ff;
      end
   end

   // Hold the frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= COUNT_W'(1);
         partial_ff <= '0;
         have_ff    <= '0;
         taint_ff   <= 1'b0;
         done_ff    <= '0;
      end else begin
         count_ff   <= count_in;
         partial_ff <= partial_in;
         have_ff    <= have_in;
         taint_ff   <= taint_in;
         done_ff    <= done_in;
      end
   end

endmodule

@@ sv/pdu_fifo.sv @@
// ----------------------------------------------------------------------------
// pdu_fifo
// Short request queue between the front and back halves.
// ----------------------------------------------------------------------------
module pdu_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  pdu_pkg::job_type wr_data,
   input  logic             rd_en,
   output pdu_pkg::job_type rd_data,
   output logic             not_empty,
   output logic             is_full
);
   import pdu_pkg::*;

   job_type              mem_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0] cnt_ff, cnt_in;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + JOB_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + JOB_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + JOB_CNT_W'(1);
      end else if (!wr_en && rd_en) begin
         cnt_in = cnt_ff - JOB_CNT_W'(1);
      end
      rd_data   = mem_ff[rd_ptr_ff];
      not_empty = cnt_ff != '0;
      is_full   = cnt_ff == JOB_CNT_W'(JOB_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the request payload
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ sv/pdu_back.sv @@
// ----------------------------------------------------------------------------
// pdu_back
// Emits the selected head-request records, one per cycle while results are
// taken, decoded into day, month and year, through an output register.
// ----------------------------------------------------------------------------
module pdu_back (
   input  logic                        clock,
   input  logic                        reset,
   input  pdu_pkg::job_type            job,
   input  logic                        job_valid,
   output logic                        job_pop,
   output logic [pdu_pkg::DAY_W-1:0]   rsp_day,
   output logic [pdu_pkg::MONTH_W-1:0] rsp_month,
   output logic [pdu_pkg::YEAR_W-1:0]  rsp_year,
   output logic                        rsp_last_of_word,
   output logic                        empty,
   input  logic                        pop
);
   import pdu_pkg::*;

   localparam int SEL_W = $clog2(MAX_RECS);

   logic [MAX_RECS-1:0]    sent_ff, sent_in;
   logic                   valid_ff, valid_in;
   logic [DAY_W-1:0]       day_ff, day_in;
   logic [MONTH_W-1:0]     month_ff, month_in;
   logic [YEAR_W-1:0]      year_ff, year_in;
   logic                   last_ff, last_in;

   logic [MAX_RECS-1:0]    pend;
   logic [SEL_W-1:0]       sel;
   logic                   is_last;
   logic [RECORD_BITS-1:0] rec;
   logic                   step;

   // Pick the lowest pending record of the head request
   always_comb begin
      pend = job.mask & ~sent_ff;
      if (pend[0]) begin
         sel     = SEL_W'(0);
         is_last = pend[2:1] == '0;
      end else if (pend[1]) begin
         sel     = SEL_W'(1);
         is_last = !pend[2];
      end else begin
         sel     = SEL_W'(2);
         is_last = 1'b1;
      end

      unique case (sel)
         SEL_W'(0): rec = job.bits[0 +: RECORD_BITS];
         SEL_W'(1): rec = job.bits[RECORD_BITS +: RECORD_BITS];
         SEL_W'(2): rec = job.bits[2*RECORD_BITS +: RECORD_BITS];
         default:   rec = '0;
      endcase

      step    = job_valid && (!valid_ff || pop);
      job_pop = step && is_last;

      // Advance the output register
      valid_in = valid_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      last_in  = last_ff;
      sent_in  = sent_ff;
      if (step) begin
         valid_in = 1'b1;
         day_in   = rec[DAY_W-1:0];
         month_in = rec[DAY_W +: MONTH_W];
         year_in  = YEAR_BASE + {{(YEAR_W - YOFS_W){1'b0}}, rec[DAY_W + MONTH_W +: YOFS_W]};
         last_in  = is_last;
         sent_in  = is_last ? '0 : (sent_ff | (MAX_RECS'(1) << sel));
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sent_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         sent_ff  <= sent_in;
      end
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      last_ff  <= last_in;
   end

   assign rsp_day          = day_ff;
   assign rsp_month        = month_ff;
   assign rsp_year         = year_ff;
   assign rsp_last_of_word = last_ff;
   assign empty            = !valid_ff;

endmodule

@@ sv/pdu_checker.sv @@
// ----------------------------------------------------------------------------
// pdu_checker
// Port-level checks of the date unpacker, bound to the top level.
// ----------------------------------------------------------------------------
`include "packed_date_unpacker_with_parity_assert.svh"

module pdu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          push,
   input logic                          full,
   input logic [pdu_pkg::DAY_W-1:0]     rsp_day,
   input logic [pdu_pkg::MONTH_W-1:0]   rsp_month,
   input logic [pdu_pkg::YEAR_W-1:0]    rsp_year,
   input logic                          rsp_last_of_word,
   input logic                          empty,
   input logic                          pop
);

   // Reset leaves nothing to deliver and room for requests
   `PDU_ASSERT_ALWAYS(a_reset_clean, reset, empty && !full, "not clean after reset")

   // Decoded year stays within its six-bit offset range
   `PDU_ASSERT_NOW(a_year_range, !empty, rsp_year >= 11'd1970 && rsp_year <= 11'd2033, "year out of range")

   // A waiting result holds until it is taken
   `PDU_ASSERT_NEXT(a_rsp_hold, !empty && !pop, !empty && $stable(rsp_day) && $stable(rsp_month) && $stable(rsp_year) && $stable(rsp_last_of_word), "result changed while waiting")

   // Nothing appears without a request in flight: empty and no push stays empty
   `PDU_ASSERT_NEXT(a_no_spurious, empty && !push && !full && $past(empty) && $past(!push) && $past(!full) && $past(empty, 2) && $past(!push, 2) && $past(!full, 2) && $past(empty, 3) && $past(!push, 3) && $past(!full, 3) && $past(empty, 4) && $past(!push, 4) && $past(!full, 4), empty, "result without request")

endmodule

bind packed_date_unpacker_with_parity pdu_checker u_pdu_checker (.*);
